>>> sv/mtsd_pkg.sv
// ----------------------------------------------------------------------------
// mtsd_pkg
// Shared types and constants for the seed and first-draw block.
// ----------------------------------------------------------------------------
package mtsd_pkg;

    localparam int WORD_W = 32;
    localparam int STEP_W = 9;

    // Step codes carried by an item as it travels the ring of cells.
    localparam logic [STEP_W-1:0] STEP_SEED = 9'd0;
    localparam logic [STEP_W-1:0] STEP_FIRST = 9'd1;
    localparam logic [STEP_W-1:0] STEP_DONE = 9'd398;

    localparam logic [WORD_W-1:0] SEED_MUL = 32'h1F1F_1F1F;
    localparam logic [WORD_W-1:0] INIT_MUL = 32'd1812433253;
    localparam logic [WORD_W-1:0] TWIST_MASK = 32'h9908_B0DF;
    localparam logic [WORD_W-1:0] UPPER_BIT = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOWER_BITS = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] TEMPER_B = 32'h9D2C_5680;
    localparam logic [WORD_W-1:0] TEMPER_C = 32'hEFC6_0000;

    // One item in flight: step count, running word, and the words kept for the twist.
    typedef struct packed {
        logic              valid;
        logic [STEP_W-1:0] step;
        logic [WORD_W-1:0] cur;
        logic [WORD_W-1:0] w0;
        logic [WORD_W-1:0] w1;
    } mtsd_slot_t;

endpackage

>>> sv/mtsd_cell.sv
// ----------------------------------------------------------------------------
// mtsd_cell
// One cell of the ring: applies one seeding step to the item it receives and
// holds the result for its neighbor.
// ----------------------------------------------------------------------------
module mtsd_cell
    import mtsd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  mtsd_slot_t slot_in,
    output mtsd_slot_t slot_out
);

    logic              valid_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [WORD_W-1:0] cur_reg, cur_next;
    logic [WORD_W-1:0] w0_reg, w0_next;
    logic [WORD_W-1:0] w1_reg, w1_next;

    logic [WORD_W-1:0]   mul_a;
    logic [WORD_W-1:0]   mul_b;
    logic [2*WORD_W-1:0] full_prod;
    logic [WORD_W-1:0]   prod;
    logic [WORD_W-1:0]   init_word;

    always_comb begin
        if (slot_in.step == STEP_SEED) begin
            mul_a = slot_in.cur;
            mul_b = SEED_MUL;
        end else begin
            mul_a = slot_in.cur ^ (slot_in.cur >> 30);
            mul_b = INIT_MUL;
        end
        full_prod = {{WORD_W{1'b0}}, mul_a} * {{WORD_W{1'b0}}, mul_b};
        prod = full_prod[WORD_W-1:0];
        init_word = prod + {{(WORD_W-STEP_W){1'b0}}, slot_in.step};

        step_next = slot_in.step;
        cur_next = slot_in.cur;
        w0_next = slot_in.w0;
        w1_next = slot_in.w1;
        if (slot_in.step == STEP_SEED) begin
            // On entry cur holds coord_x and w0 holds coord_z.
            cur_next = prod ^ slot_in.w0;
            w0_next = prod ^ slot_in.w0;
            step_next = STEP_FIRST;
        end else if (slot_in.step != STEP_DONE) begin
            cur_next = init_word;
            if (slot_in.step == STEP_FIRST) begin
                w1_next = init_word;
            end
            step_next = slot_in.step + 9'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= slot_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            step_reg <= step_next;
            cur_reg <= cur_next;
            w0_reg <= w0_next;
            w1_reg <= w1_next;
        end
    end

    assign slot_out = '{valid: valid_reg, step: step_reg, cur: cur_reg,
                        w0: w0_reg, w1: w1_reg};

endmodule

>>> sv/mtsd_out.sv
// ----------------------------------------------------------------------------
// mtsd_out
// Output stage: twists and tempers a finished item, tests it modulo 10, and
// holds the result until it is taken.
// ----------------------------------------------------------------------------
module mtsd_out
    import mtsd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  mtsd_slot_t        slot_in,
    output logic              full,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_hit_flag,
    output logic [WORD_W-1:0] m_first_draw
);

    logic              valid_reg, valid_next;
    logic              hit_reg;
    logic [WORD_W-1:0] draw_reg;

    logic [WORD_W-1:0] mixed;
    logic [WORD_W-1:0] twisted;
    logic [WORD_W-1:0] t1, t2, t3, draw;
    logic [6:0]        nib_sum;
    logic [4:0]        fold;
    logic [4:0]        r1, r2, r3;
    logic              hit;

    always_comb begin
        mixed = (slot_in.w0 & UPPER_BIT) | (slot_in.w1 & LOWER_BITS);
        twisted = slot_in.cur ^ (mixed >> 1) ^ (mixed[0] ? TWIST_MASK : '0);
        t1 = twisted ^ (twisted >> 11);
        t2 = t1 ^ ((t1 << 7) & TEMPER_B);
        t3 = t2 ^ ((t2 << 15) & TEMPER_C);
        draw = t3 ^ (t3 >> 18);

        // 16 is 1 modulo 5, so the nibble sum keeps the residue modulo 5.
        nib_sum = 7'(draw[3:0]) + 7'(draw[7:4]) + 7'(draw[11:8]) + 7'(draw[15:12])
                + 7'(draw[19:16]) + 7'(draw[23:20]) + 7'(draw[27:24])
                + 7'(draw[31:28]);
        fold = 5'(nib_sum[3:0]) + 5'(nib_sum[6:4]);
        r1 = (fold >= 5'd20) ? fold - 5'd20 : fold;
        r2 = (r1 >= 5'd10) ? r1 - 5'd10 : r1;
        r3 = (r2 >= 5'd5) ? r2 - 5'd5 : r2;
        hit = !draw[0] && (r3 == 5'd0);
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            hit_reg <= hit;
            draw_reg <= draw;
        end
    end

    assign full = valid_reg && !m_ready;
    assign m_valid = valid_reg;
    assign m_hit_flag = hit_reg;
    assign m_first_draw = draw_reg;

endmodule

>>> sv/mt19937_seed_first_draw_test_top.sv
// ----------------------------------------------------------------------------
// mt19937_seed_first_draw_test_top
// Seeds a Mersenne Twister from a grid coordinate pair and reports its first
// output word and whether that word is a multiple of 10.
// ----------------------------------------------------------------------------
// Each item takes 398 dependent steps (the seed multiply and 397 steps of the
// seeding recurrence), one step per cycle unless a finished item waits at the
// seam on a full output, in a ring of NCELL identical cells, each with one
// 32-bit multiplier. An item enters at the seam in front of the first cell,
// circles the ring until it has all its steps, leaves at the seam and is
// tempered into the output register. Up to NCELL items are in flight at once,
// so with NCELL above 1 the ring takes new items before earlier ones finish.
// A new item is taken only when the seam slot is empty or its item leaves.
module mt19937_seed_first_draw_test_top
    import mtsd_pkg::*;
#(
    parameter int NCELL = 4
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [WORD_W-1:0] s_coord_x,
    input  logic signed [WORD_W-1:0] s_coord_z,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_hit_flag,
    output logic [WORD_W-1:0]        m_first_draw
);

    mtsd_slot_t cell_in [NCELL];
    mtsd_slot_t cell_q  [NCELL];
    mtsd_slot_t last;
    mtsd_slot_t seam_slot;

    logic last_done;
    logic out_full;
    logic stall;
    logic retire;

    assign last = cell_q[NCELL-1];
    assign last_done = last.valid && (last.step == STEP_DONE);
    assign stall = last_done && out_full;
    assign retire = last_done && !stall;
    assign s_ready = !stall && (!last.valid || last_done);

    always_comb begin
        if (last.valid && !last_done) begin
            seam_slot = last;
        end else begin
            seam_slot = '{valid: s_valid && s_ready, step: STEP_SEED,
                          cur: s_coord_x, w0: s_coord_z, w1: '0};
        end
    end

    genvar i;
    generate
        for (i = 0; i < NCELL; i++) begin : g_cell
            if (i == 0) begin : g_head
                assign cell_in[i] = seam_slot;
            end else begin : g_body
                assign cell_in[i] = cell_q[i-1];
            end
            mtsd_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .advance  (!stall),
                .slot_in  (cell_in[i]),
                .slot_out (cell_q[i])
            );
        end
    endgenerate

    mtsd_out u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (retire),
        .slot_in      (last),
        .full         (out_full),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit_flag   (m_hit_flag),
        .m_first_draw (m_first_draw)
    );

    // A finished item that leaves the ring is shown on the output next cycle.
    a_retire_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        retire |=> m_valid)
        else $error("finished item not presented on the output");

    // An item still working at the seam must never be overwritten by a new one.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (last.valid && !last_done) |-> !s_ready)
        else $error("input accepted while the seam slot is busy");

    // A stalled ring keeps the finished item at the seam.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |=> last_done)
        else $error("finished item lost during an output stall");

    // Every step code in the first cell lies within the seeding range.
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_q[0].valid |-> (cell_q[0].step <= STEP_DONE))
        else $error("step count out of range");

endmodule

>>> bench/mtsd_draw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtsd_draw_checker
// Watches both channels of the seed and first-draw block, predicts the first
// tempered generator word for every accepted coordinate pair, and compares it
// with the results in order. Mismatch and progress counts go to the bench top.
// ----------------------------------------------------------------------------
module mtsd_draw_checker
    import mtsd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [WORD_W-1:0] s_coord_x,
    input  logic [WORD_W-1:0] s_coord_z,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic              m_hit_flag,
    input  logic [WORD_W-1:0] m_first_draw,
    output int                mismatch_count,
    output int                draws_pending,
    output int                draws_checked,
    output int                hits_seen
);

    localparam int                MID_OFFSET = 397;
    localparam logic [WORD_W-1:0] HIT_MODULUS = 32'd10;
    localparam int                REPORT_LIMIT = 10;

    typedef struct packed {
        logic              hit;
        logic [WORD_W-1:0] draw;
    } draw_result_t;

    draw_result_t draw_queue[$];

    // Seeds the generator only as far as the middle word, then twists word 0
    // and tempers it.
    function automatic draw_result_t predict_first_draw(logic [WORD_W-1:0] x,
                                                        logic [WORD_W-1:0] z);
        logic [WORD_W-1:0] seed;
        logic [WORD_W-1:0] cur;
        logic [WORD_W-1:0] w1;
        logic [WORD_W-1:0] y;
        draw_result_t      res;
        seed = (x * SEED_MUL) ^ z;
        cur = seed;
        w1 = '0;
        for (int i = 1; i <= MID_OFFSET; i++) begin
            cur = INIT_MUL * (cur ^ (cur >> 30)) + WORD_W'(i);
            if (i == 1) begin
                w1 = cur;
            end
        end
        y = (seed & UPPER_BIT) | (w1 & LOWER_BITS);
        y = cur ^ (y >> 1) ^ (y[0] ? TWIST_MASK : '0);
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        res.draw = y;
        res.hit = ((y % HIT_MODULUS) == '0);
        return res;
    endfunction

    always @(posedge aclk) begin
        draw_result_t got;
        draw_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                draw_queue.push_back(predict_first_draw(s_coord_x, s_coord_z));
            end
            if (m_valid && m_ready) begin
                got.hit = m_hit_flag;
                got.draw = m_first_draw;
                draws_checked++;
                if (m_hit_flag) begin
                    hits_seen++;
                end
                if (draw_queue.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: unexpected result hit_flag=%0b first_draw=%08h",
                                 $realtime, got.hit, got.draw);
                    end
                end else begin
                    want = draw_queue.pop_front();
                    if (got.hit !== want.hit || got.draw !== want.draw) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("%0t: hit_flag expected %0b got %0b, first_draw expected %08h got %08h",
                                     $realtime, want.hit, got.hit, want.draw, got.draw);
                        end
                    end
                end
            end
            draws_pending = draw_queue.size();
        end
    end

endmodule

>>> bench/tb_mt19937_seed_first_draw_test_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mt19937_seed_first_draw_test_top
// Drives coordinate pairs into the seed and first-draw block: a directed set
// of sign and wrap extremes, then random pairs, mostly with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_mt19937_seed_first_draw_test_top;
    import mtsd_pkg::*;

    localparam int RANDOM_PAIRS = 1500;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int SETTLE_CYCLES = 450;
    localparam int IDLE_PERCENT = 37;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [WORD_W-1:0] s_coord_x = '0;
    logic [WORD_W-1:0] s_coord_z = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_hit_flag;
    logic [WORD_W-1:0] m_first_draw;
    logic              steady_flow = 1'b0;

    int mismatch_count;
    int draws_pending;
    int draws_checked;
    int hits_seen;
    int pairs_sent = 0;
    int cycle_count = 0;

    mt19937_seed_first_draw_test_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_coord_x    (s_coord_x),
        .s_coord_z    (s_coord_z),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit_flag   (m_hit_flag),
        .m_first_draw (m_first_draw)
    );

    mtsd_draw_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_coord_x      (s_coord_x),
        .s_coord_z      (s_coord_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit_flag     (m_hit_flag),
        .m_first_draw   (m_first_draw),
        .mismatch_count (mismatch_count),
        .draws_pending  (draws_pending),
        .draws_checked  (draws_checked),
        .hits_seen      (hits_seen)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so the next call decides whether to drop it.
    task automatic send_pair(input logic [WORD_W-1:0] x, input logic [WORD_W-1:0] z);
        while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_coord_x <= x;
        s_coord_z <= z;
        do @(posedge aclk); while (!s_ready);
        pairs_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (draws_pending != 0) begin
            @(negedge aclk);
        end
    endtask

    initial begin
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] z;
        int                shape;

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Sign and wrap extremes, and z chosen so the seed itself is extreme.
        send_pair(32'h0000_0000, 32'h0000_0000);
        send_pair(32'h0000_0001, 32'h0000_0000);
        send_pair(32'h0000_0000, 32'h0000_0001);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(32'h8000_0000, 32'h7FFF_FFFF);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000);
        send_pair(32'h8000_0000, 32'h8000_0000);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_pair(32'hFFFF_FFFF, 32'h0000_0000);
        send_pair(32'h0000_0000, 32'hFFFF_FFFF);
        send_pair(32'h0000_0001, SEED_MUL);
        send_pair(32'h0000_0001, ~SEED_MUL);
        send_pair(32'h0000_0001, SEED_MUL ^ UPPER_BIT);
        send_pair(32'hAAAA_AAAA, 32'h5555_5555);
        send_pair(32'h5555_5555, 32'hAAAA_AAAA);
        send_pair(32'hFFFF_FC18, 32'h0000_03E8);
        drain_results();

        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            steady_flow <= (n >= 500 && n < 800);
            if (n == 1000) begin
                drain_results();
            end
            shape = $urandom_range(9);
            x = $urandom();
            z = $urandom();
            case (shape)
                4, 5: begin
                    x = $urandom_range(2000) - 1000;
                    z = $urandom_range(2000) - 1000;
                end
                6: begin
                    x = ($urandom_range(1) != 0) ? 32'h8000_0000 + $urandom_range(15)
                                                 : 32'h7FFF_FFFF - $urandom_range(15);
                end
                7: begin
                    // Small seeds: cancel the product with z.
                    z = (x * SEED_MUL) ^ $urandom_range(255);
                end
                8: begin
                    z = (x * SEED_MUL) ^ ~WORD_W'($urandom_range(255));
                end
                9: begin
                    if ($urandom_range(1) != 0) begin
                        x = '0;
                    end else begin
                        z = '0;
                    end
                end
                default: begin
                end
            endcase
            send_pair(x, z);
        end

        s_valid <= 1'b0;
        steady_flow <= 1'b0;
        @(negedge aclk);
        while (draws_pending != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("Sent %0d coordinate pairs; checked %0d first draws, %0d flagged %s",
                 pairs_sent, draws_checked, hits_seen, "as multiples of ten.");
        $display("Stimulus covered sign and wrap extremes, small and extreme seeds, and random pairs.");
        if (mismatch_count == 0 && draws_pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> files.f
sv/mtsd_pkg.sv
sv/mtsd_cell.sv
sv/mtsd_out.sv
sv/mt19937_seed_first_draw_test_top.sv
bench/mtsd_draw_checker.sv
bench/tb_mt19937_seed_first_draw_test_top.sv
